FILE: rtl/triangle_height_at_point_core_macros.svh
// ----------------------------------------------------------------------------
// Triangle height at point: assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_HEIGHT_AT_POINT_CORE_MACROS_SVH
`define TRIANGLE_HEIGHT_AT_POINT_CORE_MACROS_SVH

// Same-cycle implication.
`define THAP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define THAP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/thap_pkg.sv
// ----------------------------------------------------------------------------
// thap_pkg
// Fixed-point types, widths and saturating arithmetic for the height query.
// ----------------------------------------------------------------------------
`default_nettype none

package thap_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FX_W      = 32;

    typedef logic signed [FX_W-1:0] fx_t;

    typedef struct packed {
        fx_t x;
        fx_t y;
        fx_t z;
    } vec_t;

    localparam fx_t FX_MAX = 32'sh7FFF_FFFF;
    localparam fx_t FX_MIN = 32'sh8000_0000;
    localparam logic signed [2*FX_W-1:0] P_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [2*FX_W-1:0] P_MIN = -64'sh0000_0000_8000_0000;
    localparam logic signed [2*FX_W-1:0] FX_RND = 64'sd1 <<< (FRAC_BITS - 1);

    // Thresholds: 0.0001 and 0.001, rounded to the grid.
    localparam int  EPS_DEN_I  = ((1 << FRAC_BITS) + 5000) / 10000;
    localparam int  EDGE_TOL_I = ((1 << FRAC_BITS) + 500) / 1000;
    localparam fx_t EPS_DEN    = fx_t'(EPS_DEN_I);
    localparam fx_t EPS_NEG    = fx_t'(-EPS_DEN_I);
    localparam fx_t EDGE_TOL   = fx_t'(EDGE_TOL_I);

    // Square root: radicand is a non-negative value shifted up by FRAC_BITS.
    localparam int SQ_IT  = (FX_W + FRAC_BITS) / 2;
    localparam int SQ_ST  = (SQ_IT + 1) / 2;
    localparam int SQ_VW  = 4 * SQ_ST;
    localparam int SQ_RTW = 2 * SQ_ST;
    localparam int SQ_RMW = SQ_RTW + 2;

    // Divider: magnitude of dividend shifted up by FRAC_BITS, two bits a stage.
    localparam int DV_ST  = (FX_W + FRAC_BITS + 1) / 2;
    localparam int DV_W   = 2 * DV_ST;
    localparam int DV_LAT = DV_ST + 2;

    function automatic fx_t fx_add(input fx_t a, input fx_t b);
        logic [FX_W:0] s;
        s = {a[FX_W-1], a} + {b[FX_W-1], b};
        if (s[FX_W] != s[FX_W-1]) begin
            return s[FX_W] ? FX_MIN : FX_MAX;
        end
        return s[FX_W-1:0];
    endfunction

    function automatic fx_t fx_sub(input fx_t a, input fx_t b);
        logic [FX_W:0] s;
        s = {a[FX_W-1], a} - {b[FX_W-1], b};
        if (s[FX_W] != s[FX_W-1]) begin
            return s[FX_W] ? FX_MIN : FX_MAX;
        end
        return s[FX_W-1:0];
    endfunction

    // Round half up, floor shift, saturate.
    function automatic fx_t fx_mul(input fx_t a, input fx_t b);
        logic signed [2*FX_W-1:0] p;
        logic signed [2*FX_W-1:0] q;
        p = a * b;
        p = p + FX_RND;
        q = p >>> FRAC_BITS;
        if (q > P_MAX) begin
            return FX_MAX;
        end
        if (q < P_MIN) begin
            return FX_MIN;
        end
        return q[FX_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/triangle_height_at_point_core.sv
// ----------------------------------------------------------------------------
// triangle_height_at_point_core
// Vertical ray against a triangle: height of the surface under a query point.
// ----------------------------------------------------------------------------
// Each input item holds a query point (x, z) and the three vertices of a
// triangle, all signed Q16.16; each item yields one result item with the
// height of the triangle's plane under the point and a hit flag (height is
// zero on a miss). The core is a fully pipelined datapath that takes one
// item per clock while the output is not stalled, and returns Q16.16 results in order:
// five stages form the edge vectors, the plane normal and its squared
// length, a two-bit-per-stage square root takes SQ_ST stages, three
// parallel two-bit-per-stage dividers scale the normal to unit length,
// three stages build the plane equation and edge normals, a second divider
// solves for the height, and three stages run the edge half-plane tests
// into the output register. All stages advance together while the output
// register is empty or being read, so s_ready follows m_ready within the
// cycle and no item is dropped or repeated under back-pressure. There is no
// configuration and no state beyond the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangle_height_at_point_core_macros.svh"

module triangle_height_at_point_core import thap_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  fx_t  s_query_x,
    input  fx_t  s_query_z,
    input  fx_t  s_vert_a_x,
    input  fx_t  s_vert_a_y,
    input  fx_t  s_vert_a_z,
    input  fx_t  s_vert_b_x,
    input  fx_t  s_vert_b_y,
    input  fx_t  s_vert_b_z,
    input  fx_t  s_vert_c_x,
    input  fx_t  s_vert_c_y,
    input  fx_t  s_vert_c_z,
    output logic m_valid,
    input  logic m_ready,
    output fx_t  m_height,
    output logic m_hit
);

    typedef struct packed {
        fx_t  qx;
        fx_t  qz;
        vec_t a;
        vec_t b;
        vec_t c;
    } pts_t;

    // Points plus the three directed edges A->B, B->C, C->A.
    typedef struct packed {
        pts_t           pts;
        vec_t [2:0]     edg;
    } geo_t;

    // What rides alongside the height divider.
    typedef struct packed {
        pts_t           pts;
        vec_t [2:0]     en;
        logic           ok;
    } tail_t;

    function automatic vec_t vsub(input vec_t p, input vec_t q);
        vec_t r;
        r.x = fx_sub(p.x, q.x);
        r.y = fx_sub(p.y, q.y);
        r.z = fx_sub(p.z, q.z);
        return r;
    endfunction

    // Global advance: move everything while the output can take a new item.
    logic m_valid_reg;
    logic pipe_en;
    assign pipe_en = !m_valid_reg || m_ready;
    assign s_ready = pipe_en;

    // ---------------------------------------------------------------- input
    pts_t in_pts;
    assign in_pts.qx = s_query_x;
    assign in_pts.qz = s_query_z;
    assign in_pts.a  = '{s_vert_a_x, s_vert_a_y, s_vert_a_z};
    assign in_pts.b  = '{s_vert_b_x, s_vert_b_y, s_vert_b_z};
    assign in_pts.c  = '{s_vert_c_x, s_vert_c_y, s_vert_c_z};

    // ------------------------------------------------- normal, P1 through P5
    geo_t p1_geo_reg, p2_geo_reg, p3_geo_reg, p4_geo_reg, p5_geo_reg;
    vec_t p1_ac_reg;
    fx_t  p2_cp_reg [6];
    vec_t p3_n_reg, p4_n_reg, p5_n_reg;
    fx_t  p4_sq_reg [3];
    fx_t  p5_mag2_reg;
    logic p1_vld_reg, p2_vld_reg, p3_vld_reg, p4_vld_reg, p5_vld_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            // P1: edge vectors (e1 = A->B, e2 = A->C)
            p1_geo_reg.pts    <= in_pts;
            p1_geo_reg.edg[0] <= vsub(in_pts.b, in_pts.a);
            p1_geo_reg.edg[1] <= vsub(in_pts.c, in_pts.b);
            p1_geo_reg.edg[2] <= vsub(in_pts.a, in_pts.c);
            p1_ac_reg         <= vsub(in_pts.c, in_pts.a);
            // P2: cross product terms of e1 x e2
            p2_geo_reg   <= p1_geo_reg;
            p2_cp_reg[0] <= fx_mul(p1_geo_reg.edg[0].y, p1_ac_reg.z);
            p2_cp_reg[1] <= fx_mul(p1_geo_reg.edg[0].z, p1_ac_reg.y);
            p2_cp_reg[2] <= fx_mul(p1_geo_reg.edg[0].z, p1_ac_reg.x);
            p2_cp_reg[3] <= fx_mul(p1_geo_reg.edg[0].x, p1_ac_reg.z);
            p2_cp_reg[4] <= fx_mul(p1_geo_reg.edg[0].x, p1_ac_reg.y);
            p2_cp_reg[5] <= fx_mul(p1_geo_reg.edg[0].y, p1_ac_reg.x);
            // P3: normal
            p3_geo_reg <= p2_geo_reg;
            p3_n_reg.x <= fx_sub(p2_cp_reg[0], p2_cp_reg[1]);
            p3_n_reg.y <= fx_sub(p2_cp_reg[2], p2_cp_reg[3]);
            p3_n_reg.z <= fx_sub(p2_cp_reg[4], p2_cp_reg[5]);
            // P4: squares
            p4_geo_reg   <= p3_geo_reg;
            p4_n_reg     <= p3_n_reg;
            p4_sq_reg[0] <= fx_mul(p3_n_reg.x, p3_n_reg.x);
            p4_sq_reg[1] <= fx_mul(p3_n_reg.y, p3_n_reg.y);
            p4_sq_reg[2] <= fx_mul(p3_n_reg.z, p3_n_reg.z);
            // P5: squared length, never negative
            p5_geo_reg  <= p4_geo_reg;
            p5_n_reg    <= p4_n_reg;
            p5_mag2_reg <= fx_add(fx_add(p4_sq_reg[0], p4_sq_reg[1]), p4_sq_reg[2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            p4_vld_reg <= 1'b0;
            p5_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            p1_vld_reg <= s_valid;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            p4_vld_reg <= p3_vld_reg;
            p5_vld_reg <= p4_vld_reg;
        end
    end

    // ------------------------------------------------------------ magnitude
    logic [SQ_VW-1:0]  sq_rad;
    logic [SQ_RTW-1:0] sq_root;

    assign sq_rad = SQ_VW'({p5_mag2_reg[FX_W-2:0], {FRAC_BITS{1'b0}}});

    thap_sqrt u_sqrt (
        .aclk (aclk),
        .en   (pipe_en),
        .rad  (sq_rad),
        .root (sq_root)
    );

    // Hold normal and geometry alongside the root.
    vec_t             sd_n_reg   [SQ_ST];
    geo_t             sd_geo_reg [SQ_ST];
    logic [SQ_ST-1:0] sd_vld_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sd_n_reg[0]   <= p5_n_reg;
            sd_geo_reg[0] <= p5_geo_reg;
            for (int i = 1; i < SQ_ST; i++) begin
                sd_n_reg[i]   <= sd_n_reg[i-1];
                sd_geo_reg[i] <= sd_geo_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sd_vld_reg <= '0;
        end else if (pipe_en) begin
            sd_vld_reg <= {sd_vld_reg[SQ_ST-2:0], p5_vld_reg};
        end
    end

    // --------------------------------------------------------- unit normal
    fx_t  mag_fx;
    vec_t unit;

    assign mag_fx = fx_t'(sq_root);

    thap_div u_div_ux (
        .aclk (aclk),
        .en   (pipe_en),
        .num  (sd_n_reg[SQ_ST-1].x),
        .den  (mag_fx),
        .quo  (unit.x)
    );

    thap_div u_div_uy (
        .aclk (aclk),
        .en   (pipe_en),
        .num  (sd_n_reg[SQ_ST-1].y),
        .den  (mag_fx),
        .quo  (unit.y)
    );

    thap_div u_div_uz (
        .aclk (aclk),
        .en   (pipe_en),
        .num  (sd_n_reg[SQ_ST-1].z),
        .den  (mag_fx),
        .quo  (unit.z)
    );

    geo_t              ud_geo_reg [DV_LAT];
    logic [DV_LAT-1:0] ud_vld_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ud_geo_reg[0] <= sd_geo_reg[SQ_ST-1];
            for (int i = 1; i < DV_LAT; i++) begin
                ud_geo_reg[i] <= ud_geo_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ud_vld_reg <= '0;
        end else if (pipe_en) begin
            ud_vld_reg <= {ud_vld_reg[DV_LAT-2:0], sd_vld_reg[SQ_ST-1]};
        end
    end

    // ------------------------------------------ plane and edge normals, Q1-Q3
    geo_t ug;
    logic u_ok;

    assign ug   = ud_geo_reg[DV_LAT-1];
    // Plane too steep: vertical component of the unit normal near zero.
    assign u_ok = (unit.y != '0) && ((unit.y >= EPS_DEN) || (unit.y <= EPS_NEG));

    fx_t        q1_pu_reg [3];
    fx_t        q1_pqx_reg, q1_pqz_reg, q1_uy_reg;
    fx_t        q1_cp_reg [3][6];
    logic       q1_ok_reg;
    pts_t       q1_pts_reg;
    fx_t        q2_dua_reg, q2_pqx_reg, q2_pqz_reg, q2_uy_reg;
    vec_t [2:0] q2_en_reg;
    logic       q2_ok_reg;
    pts_t       q2_pts_reg;
    fx_t        q3_num_reg, q3_uy_reg;
    vec_t [2:0] q3_en_reg;
    logic       q3_ok_reg;
    pts_t       q3_pts_reg;
    logic       q1_vld_reg, q2_vld_reg, q3_vld_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            // Q1: all products against the unit normal
            q1_pu_reg[0] <= fx_mul(unit.x, ug.pts.a.x);
            q1_pu_reg[1] <= fx_mul(unit.y, ug.pts.a.y);
            q1_pu_reg[2] <= fx_mul(unit.z, ug.pts.a.z);
            q1_pqx_reg   <= fx_mul(unit.x, ug.pts.qx);
            q1_pqz_reg   <= fx_mul(unit.z, ug.pts.qz);
            for (int e = 0; e < 3; e++) begin
                q1_cp_reg[e][0] <= fx_mul(ug.edg[e].y, unit.z);
                q1_cp_reg[e][1] <= fx_mul(ug.edg[e].z, unit.y);
                q1_cp_reg[e][2] <= fx_mul(ug.edg[e].z, unit.x);
                q1_cp_reg[e][3] <= fx_mul(ug.edg[e].x, unit.z);
                q1_cp_reg[e][4] <= fx_mul(ug.edg[e].x, unit.y);
                q1_cp_reg[e][5] <= fx_mul(ug.edg[e].y, unit.x);
            end
            q1_uy_reg  <= unit.y;
            q1_ok_reg  <= u_ok;
            q1_pts_reg <= ug.pts;
            // Q2: u . A and edge normals
            q2_dua_reg <= fx_add(fx_add(q1_pu_reg[0], q1_pu_reg[1]), q1_pu_reg[2]);
            for (int e = 0; e < 3; e++) begin
                q2_en_reg[e].x <= fx_sub(q1_cp_reg[e][0], q1_cp_reg[e][1]);
                q2_en_reg[e].y <= fx_sub(q1_cp_reg[e][2], q1_cp_reg[e][3]);
                q2_en_reg[e].z <= fx_sub(q1_cp_reg[e][4], q1_cp_reg[e][5]);
            end
            q2_pqx_reg <= q1_pqx_reg;
            q2_pqz_reg <= q1_pqz_reg;
            q2_uy_reg  <= q1_uy_reg;
            q2_ok_reg  <= q1_ok_reg;
            q2_pts_reg <= q1_pts_reg;
            // Q3: numerator of the height
            q3_num_reg <= fx_sub(fx_sub(q2_dua_reg, q2_pqx_reg), q2_pqz_reg);
            q3_uy_reg  <= q2_uy_reg;
            q3_en_reg  <= q2_en_reg;
            q3_ok_reg  <= q2_ok_reg;
            q3_pts_reg <= q2_pts_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q1_vld_reg <= 1'b0;
            q2_vld_reg <= 1'b0;
            q3_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            q1_vld_reg <= ud_vld_reg[DV_LAT-1];
            q2_vld_reg <= q1_vld_reg;
            q3_vld_reg <= q2_vld_reg;
        end
    end

    // --------------------------------------------------------------- height
    fx_t h_quo;

    thap_div u_div_h (
        .aclk (aclk),
        .en   (pipe_en),
        .num  (q3_num_reg),
        .den  (q3_uy_reg),
        .quo  (h_quo)
    );

    tail_t             hd_tl_reg [DV_LAT];
    logic [DV_LAT-1:0] hd_vld_reg;
    tail_t             hd_in;

    assign hd_in.pts = q3_pts_reg;
    assign hd_in.en  = q3_en_reg;
    assign hd_in.ok  = q3_ok_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            hd_tl_reg[0] <= hd_in;
            for (int i = 1; i < DV_LAT; i++) begin
                hd_tl_reg[i] <= hd_tl_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hd_vld_reg <= '0;
        end else if (pipe_en) begin
            hd_vld_reg <= {hd_vld_reg[DV_LAT-2:0], q3_vld_reg};
        end
    end

    // ------------------------------------------------------ edge tests, R1-R2
    tail_t      ht;
    vec_t       hq;
    vec_t [2:0] r1_d_reg;
    vec_t [2:0] r1_en_reg;
    fx_t        r1_h_reg, r2_h_reg;
    logic       r1_ok_reg, r2_ok_reg;
    fx_t        r2_p_reg [3][3];
    logic       r1_vld_reg, r2_vld_reg;

    assign ht = hd_tl_reg[DV_LAT-1];
    assign hq = '{ht.pts.qx, h_quo, ht.pts.qz};

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            // R1: hit point relative to each edge start
            r1_d_reg[0] <= vsub(hq, ht.pts.a);
            r1_d_reg[1] <= vsub(hq, ht.pts.b);
            r1_d_reg[2] <= vsub(hq, ht.pts.c);
            r1_en_reg   <= ht.en;
            r1_h_reg    <= h_quo;
            r1_ok_reg   <= ht.ok;
            // R2: dot product terms
            for (int e = 0; e < 3; e++) begin
                r2_p_reg[e][0] <= fx_mul(r1_en_reg[e].x, r1_d_reg[e].x);
                r2_p_reg[e][1] <= fx_mul(r1_en_reg[e].y, r1_d_reg[e].y);
                r2_p_reg[e][2] <= fx_mul(r1_en_reg[e].z, r1_d_reg[e].z);
            end
            r2_h_reg  <= r1_h_reg;
            r2_ok_reg <= r1_ok_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_vld_reg <= 1'b0;
            r2_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            r1_vld_reg <= hd_vld_reg[DV_LAT-1];
            r2_vld_reg <= r1_vld_reg;
        end
    end

    // --------------------------------------------------------------- output
    logic [2:0] outside;
    logic       m_hit_next;
    fx_t        m_height_next;
    logic       m_hit_reg;
    fx_t        m_height_reg;

    always_comb begin
        fx_t s;
        for (int e = 0; e < 3; e++) begin
            s = fx_add(fx_add(r2_p_reg[e][0], r2_p_reg[e][1]), r2_p_reg[e][2]);
            outside[e] = (s > EDGE_TOL);
        end
        m_hit_next    = r2_ok_reg && (outside == '0);
        // drop the height on a miss
        m_height_next = m_hit_next ? r2_h_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m_hit_reg    <= m_hit_next;
            m_height_reg <= m_height_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= r2_vld_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_hit    = m_hit_reg;
    assign m_height = m_height_reg;

    // ----------------------------------------------------------- assertions
    `THAP_ASSERT_SAME(a_miss_zero, m_valid_reg && !m_hit_reg, m_height_reg == '0, "miss with nonzero height")
    `THAP_ASSERT_NEXT(a_stall_hold, !pipe_en, $stable(ud_vld_reg) && $stable(hd_vld_reg), "valid moved during stall")
    `THAP_ASSERT_NEXT(a_last_to_out, pipe_en && r2_vld_reg, m_valid_reg, "item lost at output")

endmodule

`default_nettype wire

FILE: rtl/thap_sqrt.sv
// ----------------------------------------------------------------------------
// thap_sqrt
// Pipelined integer square root, two result bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module thap_sqrt import thap_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [SQ_VW-1:0]  rad,
    output logic [SQ_RTW-1:0] root
);

    logic [SQ_VW-1:0]  v_reg    [SQ_ST];
    logic [SQ_RMW-1:0] rem_reg  [SQ_ST];
    logic [SQ_RTW-1:0] root_reg [SQ_ST];
    logic [SQ_VW-1:0]  v_next    [SQ_ST];
    logic [SQ_RMW-1:0] rem_next  [SQ_ST];
    logic [SQ_RTW-1:0] root_next [SQ_ST];

    always_comb begin
        logic [SQ_VW-1:0]  v;
        logic [SQ_RMW-1:0] r;
        logic [SQ_RMW-1:0] t;
        logic [SQ_RTW-1:0] q;
        for (int s = 0; s < SQ_ST; s++) begin
            if (s == 0) begin
                v = rad;
                r = '0;
                q = '0;
            end else begin
                v = v_reg[s-1];
                r = rem_reg[s-1];
                q = root_reg[s-1];
            end
            for (int k = 0; k < 2; k++) begin
                // bring down the next bit pair, try the next root bit
                r = {r[SQ_RMW-3:0], v[SQ_VW-1 -: 2]};
                v = v << 2;
                t = {q, 2'b01};
                if (r >= t) begin
                    r = r - t;
                    q = {q[SQ_RTW-2:0], 1'b1};
                end else begin
                    q = {q[SQ_RTW-2:0], 1'b0};
                end
            end
            v_next[s]    = v;
            rem_next[s]  = r;
            root_next[s] = q;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < SQ_ST; s++) begin
                v_reg[s]    <= v_next[s];
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
            end
        end
    end

    assign root = root_reg[SQ_ST-1];

endmodule

`default_nettype wire

FILE: rtl/thap_div.sv
// ----------------------------------------------------------------------------
// thap_div
// Pipelined fixed-point divide: (num << FRAC_BITS) / den, toward zero, saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module thap_div import thap_pkg::*; (
    input  logic aclk,
    input  logic en,
    input  fx_t  num,
    input  fx_t  den,
    output fx_t  quo
);

    localparam logic [DV_W-1:0] LIM_POS = DV_W'(33'h0_7FFF_FFFF);
    localparam logic [DV_W-1:0] LIM_NEG = DV_W'(33'h0_8000_0000);

    logic [DV_W-1:0] acc_reg  [DV_ST+1];
    logic [FX_W:0]   rem_reg  [DV_ST+1];
    logic [FX_W-1:0] dmag_reg [DV_ST+1];
    logic [DV_ST:0]  neg_reg;
    logic [DV_ST:0]  zero_reg;
    logic [DV_W-1:0] acc_next [DV_ST+1];
    logic [FX_W:0]   rem_next [DV_ST+1];
    logic [FX_W-1:0] nabs;
    fx_t             quo_reg;
    fx_t             quo_next;

    assign nabs = num[FX_W-1] ? (~num + 1'b1) : num;

    always_comb begin
        logic [DV_W-1:0] a;
        logic [FX_W:0]   r;
        acc_next[0] = DV_W'({nabs, {FRAC_BITS{1'b0}}});
        rem_next[0] = '0;
        for (int s = 1; s <= DV_ST; s++) begin
            a = acc_reg[s-1];
            r = rem_reg[s-1];
            for (int k = 0; k < 2; k++) begin
                // shift one dividend bit into the remainder, quotient bit in at the bottom
                r = {r[FX_W-1:0], a[DV_W-1]};
                a = a << 1;
                if (r >= {1'b0, dmag_reg[s-1]}) begin
                    r    = r - {1'b0, dmag_reg[s-1]};
                    a[0] = 1'b1;
                end
            end
            acc_next[s] = a;
            rem_next[s] = r;
        end
    end

    always_comb begin
        logic [DV_W-1:0] q;
        q = acc_reg[DV_ST];
        if (zero_reg[DV_ST]) begin
            quo_next = '0;
        end else if (neg_reg[DV_ST]) begin
            quo_next = (q > LIM_NEG) ? FX_MIN : fx_t'(-q[FX_W-1:0]);
        end else begin
            quo_next = (q > LIM_POS) ? FX_MAX : fx_t'(q[FX_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s <= DV_ST; s++) begin
                acc_reg[s] <= acc_next[s];
                rem_reg[s] <= rem_next[s];
            end
            dmag_reg[0] <= den[FX_W-1] ? (~den + 1'b1) : den;
            neg_reg[0]  <= num[FX_W-1] ^ den[FX_W-1];
            zero_reg[0] <= (den == '0);
            for (int s = 1; s <= DV_ST; s++) begin
                dmag_reg[s] <= dmag_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
            end
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

FILE: tb/triangle_height_at_point_core_tb.sv
// ----------------------------------------------------------------------------
// triangle_height_at_point_core_tb
// Self-checking bench for the vertical-ray triangle height core.
// ----------------------------------------------------------------------------
// A short table of hand-picked items runs first. Some rows carry their
// expected result typed in: degenerate triangles and vertical planes always
// miss with height zero. All other rows, and the random items that follow,
// are checked against a fixed-point height predictor kept in this file.
// Most random items are well-formed triangles with the query point near
// their middle, so the plane solve and the edge tests are exercised. The
// rest are full-range noise. Both sides idle at random. Once, the result
// side holds off for a long stretch so that the pipeline fills and stalls
// its input.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_height_at_point_core_tb;
    import thap_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  NUM_RANDOM   = 800;
    localparam int  IDLE_LIMIT   = 5000;
    localparam int  HOLD_CYCLES  = 400;
    localparam int  HOLD_AT      = 200;
    localparam int  DRAIN_CYCLES = 120;
    localparam fx_t ONE          = 32'sh0001_0000;
    localparam longint QONE      = 64'sd65536;
    localparam longint EPS_Q     = (QONE + 5000) / 10000;
    localparam longint TOL_Q     = (QONE + 500) / 1000;

    typedef longint vec3_t [3];

    typedef struct {
        fx_t qx, qz;
        fx_t ax, ay, az;
        fx_t bx, by, bz;
        fx_t cx, cy, cz;
    } query_t;

    typedef struct {
        fx_t  height;
        logic hit;
    } height_t;

    typedef struct {
        query_t q;
        bit     typed;
        fx_t    height;
        logic   hit;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    fx_t  s_query_x = '0, s_query_z = '0;
    fx_t  s_vert_a_x = '0, s_vert_a_y = '0, s_vert_a_z = '0;
    fx_t  s_vert_b_x = '0, s_vert_b_y = '0, s_vert_b_z = '0;
    fx_t  s_vert_c_x = '0, s_vert_c_y = '0, s_vert_c_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    fx_t  m_height;
    logic m_hit;

    height_t pending_heights[$];
    int      mismatches = 0;
    int      sent_count = 0;
    int      got_count = 0;
    int      idle_cycles = 0;
    bit      holding = 1'b0;

    triangle_height_at_point_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_query_x(s_query_x), .s_query_z(s_query_z),
        .s_vert_a_x(s_vert_a_x), .s_vert_a_y(s_vert_a_y), .s_vert_a_z(s_vert_a_z),
        .s_vert_b_x(s_vert_b_x), .s_vert_b_y(s_vert_b_y), .s_vert_b_z(s_vert_b_z),
        .s_vert_c_x(s_vert_c_x), .s_vert_c_y(s_vert_c_y), .s_vert_c_z(s_vert_c_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_height(m_height), .m_hit(m_hit)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Fixed-point height predictor, all math in 64 bits then clamped.
    // ------------------------------------------------------------------
    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Round half up: add half an LSB, then floor via arithmetic shift.
    function automatic longint qmul(longint a, longint b);
        return clamp32((a * b + QONE / 2) >>> 16);
    endfunction

    // Truncate toward zero; a zero divisor yields zero.
    function automatic longint qdiv(longint a, longint b);
        if (b == 0) return 0;
        return clamp32((a * QONE) / b);
    endfunction

    function automatic longint qsqrt(longint m);
        longint unsigned v, root, bitv;
        if (m <= 0) return 0;
        v = longint'(m) * QONE;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return clamp32(longint'(root));
    endfunction

    function automatic vec3_t cross3(vec3_t p, vec3_t r);
        vec3_t o;
        o[0] = clamp32(qmul(p[1], r[2]) - qmul(p[2], r[1]));
        o[1] = clamp32(qmul(p[2], r[0]) - qmul(p[0], r[2]));
        o[2] = clamp32(qmul(p[0], r[1]) - qmul(p[1], r[0]));
        return o;
    endfunction

    function automatic longint dot3(vec3_t p, vec3_t r);
        return clamp32(clamp32(qmul(p[0], r[0]) + qmul(p[1], r[1])) + qmul(p[2], r[2]));
    endfunction

    // True when the point lies beyond the edge s->e by more than the tolerance.
    function automatic bit beyond_edge(vec3_t s, vec3_t e, vec3_t u, vec3_t p);
        vec3_t ev, dv;
        for (int i = 0; i < 3; i++) begin
            ev[i] = clamp32(e[i] - s[i]);
            dv[i] = clamp32(p[i] - s[i]);
        end
        return dot3(cross3(ev, u), dv) > TOL_Q;
    endfunction

    function automatic height_t surface_height(query_t q);
        vec3_t   va, vb, vc, e1, e2, n, u, p;
        longint  mag, num, h;
        bit      hit;
        height_t r;
        va = '{longint'(q.ax), longint'(q.ay), longint'(q.az)};
        vb = '{longint'(q.bx), longint'(q.by), longint'(q.bz)};
        vc = '{longint'(q.cx), longint'(q.cy), longint'(q.cz)};
        for (int i = 0; i < 3; i++) begin
            e1[i] = clamp32(vb[i] - va[i]);
            e2[i] = clamp32(vc[i] - va[i]);
        end
        n = cross3(e1, e2);
        mag = qsqrt(dot3(n, n));
        for (int i = 0; i < 3; i++) u[i] = qdiv(n[i], mag);
        hit = 1'b0;
        h = 0;
        // A near-vertical plane, or a degenerate triangle, never hits.
        if (u[1] >= EPS_Q || u[1] <= -EPS_Q) begin
            num = clamp32(clamp32(dot3(u, va) - qmul(u[0], q.qx)) - qmul(u[2], q.qz));
            h = qdiv(num, u[1]);
            p = '{longint'(q.qx), h, longint'(q.qz)};
            hit = !beyond_edge(va, vb, u, p) && !beyond_edge(vb, vc, u, p)
                && !beyond_edge(vc, va, u, p);
        end
        r.height = hit ? fx_t'(h) : '0;
        r.hit = hit;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table. Rows with typed results are the obvious misses.
    // ------------------------------------------------------------------
    row_t dir_rows[] = '{
        // all zero: degenerate, miss
        '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, 0, 1'b0},
        // vertical plane z = 0: normal has no y component
        '{'{32'sh4000, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0}, 1'b1, 0, 1'b0},
        // collinear vertices: degenerate
        '{'{0, 0, 0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE}, 1'b1, 0, 1'b0},
        // every field at the top of its range: all vertices coincide
        '{'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
            32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
            32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, 1'b1, 0, 1'b0},
        // every field at the bottom of its range
        '{'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
            32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
            32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 1'b1, 0, 1'b0},
        // flat unit triangle, point inside, then outside
        '{'{32'sh4000, 32'sh4000, 0, 0, 0, ONE, 0, 0, 0, 0, ONE}, 1'b0, 0, 1'b0},
        '{'{2*ONE, 2*ONE, 0, 0, 0, ONE, 0, 0, 0, 0, ONE}, 1'b0, 0, 1'b0},
        // reversed winding
        '{'{32'sh4000, 32'sh4000, 0, 0, 0, 0, 0, ONE, ONE, 0, 0}, 1'b0, 0, 1'b0},
        // raised and sloped plane
        '{'{32'sh3000, 32'sh5000, 0, 3*ONE, 0, 4*ONE, 5*ONE, 0, 0, -ONE, 4*ONE},
          1'b0, 0, 1'b0},
        // point on an edge and on a vertex
        '{'{32'sh8000, 0, 0, ONE, 0, ONE, ONE, 0, 0, ONE, ONE}, 1'b0, 0, 1'b0},
        '{'{ONE, 0, 0, 0, 0, ONE, 0, 0, 0, 0, ONE}, 1'b0, 0, 1'b0},
        // just outside an edge, near the tolerance
        '{'{32'sh8020, 32'sh8020, 0, 0, 0, ONE, 0, 0, 0, 0, ONE}, 1'b0, 0, 1'b0},
        // steep plane with a tiny vertical component
        '{'{32'sh100, 32'sh1, 0, 0, 0, ONE, 0, 0, 0, 100*ONE, 1}, 1'b0, 0, 1'b0},
        // huge triangle and extreme coordinates, saturation everywhere
        '{'{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh8000_0000,
            32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF},
          1'b0, 0, 1'b0},
        '{'{-1, -1, 32'sh7FFF_FFFF, -1, 32'sh8000_0000, 32'sh8000_0000, 1, 0,
            0, 32'sh7FFF_FFFF, -1}, 1'b0, 0, 1'b0},
        // large flat triangle with a big height offset
        '{'{-5*ONE, 3*ONE, -100*ONE, 32'sh7000_0000, -100*ONE, 100*ONE,
            32'sh7000_0000, -100*ONE, 0, 32'sh7000_0000, 100*ONE}, 1'b0, 0, 1'b0}
    };

    function automatic fx_t rnd32();
        return fx_t'($urandom);
    endfunction

    // Well-formed triangles with small coordinates most of the time, query
    // near the centroid, sometimes with jitter; a fifth of items are full-range noise.
    function automatic query_t random_query();
        query_t q;
        int     span, pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            q = '{rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(),
                  rnd32(), rnd32(), rnd32(), rnd32()};
            return q;
        end
        span = 1 << $urandom_range(10, 22);
        q.ax = fx_t'($urandom_range(0, 2 * span) - span);
        q.az = fx_t'($urandom_range(0, 2 * span) - span);
        q.bx = fx_t'($urandom_range(0, 2 * span) - span);
        q.bz = fx_t'($urandom_range(0, 2 * span) - span);
        q.cx = fx_t'($urandom_range(0, 2 * span) - span);
        q.cz = fx_t'($urandom_range(0, 2 * span) - span);
        q.ay = fx_t'($urandom_range(0, 2 * span) - span);
        q.by = fx_t'($urandom_range(0, 2 * span) - span);
        q.cy = fx_t'($urandom_range(0, 2 * span) - span);
        q.qx = fx_t'((longint'(q.ax) + q.bx + q.cx) / 3);
        q.qz = fx_t'((longint'(q.az) + q.bz + q.cz) / 3);
        if (pick > 5) begin
            q.qx = q.qx + fx_t'($urandom_range(0, span) - span / 2);
            q.qz = q.qz + fx_t'($urandom_range(0, span) - span / 2);
        end
        return q;
    endfunction

    // Draw an idle count; every fourth block of 64 items runs back to back.
    function automatic int idle_draw(int count);
        if (((count / 64) % 4) == 3) return 0;
        return $urandom_range(0, 17);
    endfunction

    // Offer one item, then hold it until accepted and log its expectation.
    task automatic offer(query_t q, height_t want);
        int gap;
        gap = holding ? 0 : idle_draw(sent_count);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_query_x <= q.qx;  s_query_z <= q.qz;
        s_vert_a_x <= q.ax; s_vert_a_y <= q.ay; s_vert_a_z <= q.az;
        s_vert_b_x <= q.bx; s_vert_b_y <= q.by; s_vert_b_z <= q.bz;
        s_vert_c_x <= q.cx; s_vert_c_y <= q.cy; s_vert_c_z <= q.cz;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
        pending_heights.push_back(want);
        sent_count++;
    endtask

    task automatic report(string what, height_t want);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] %s: expected height %0d hit %0b, got height %0d hit %0b",
                     $realtime, what, want.height, want.hit, m_height, m_hit);
        end
    endtask

    // Result side: random stalls, one long hold-off to back up the pipeline.
    initial begin : result_side
        int      gap;
        height_t want;
        @(posedge aresetn);
        forever begin
            if (got_count == HOLD_AT) begin
                holding = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holding = 1'b0;
            end else begin
                gap = idle_draw(got_count + 32);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            got_count++;
            if (pending_heights.size() == 0) begin
                want = '{'0, 1'b0};
                report("unexpected result", want);
            end else begin
                want = pending_heights.pop_front();
                if (m_height !== want.height || m_hit !== want.hit) begin
                    report("result mismatch", want);
                end
            end
        end
    end

    // Watchdog: give up when neither side has moved for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (aresetn) begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        height_t want;
        query_t  q;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table; typed rows use their typed result instead of the predictor.
        foreach (dir_rows[i]) begin
            want = surface_height(dir_rows[i].q);
            if (dir_rows[i].typed) begin
                want.height = dir_rows[i].height;
                want.hit = dir_rows[i].hit;
            end
            offer(dir_rows[i].q, want);
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            q = random_query();
            offer(q, surface_height(q));
        end
        s_valid <= 1'b0;

        // Drain: wait for every result, then a little past the latency.
        while (pending_heights.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
